>>> design/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and helpers of the escape-time pixel unit.
// ----------------------------------------------------------------------------
package met_pkg;

    // image size and fixed-point format
    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;
    localparam int FRAC_BITS    = 28;

    // field widths
    localparam int WORD_W   = 32;
    localparam int STEP_W   = 31;
    localparam int ITER_W   = 16;
    localparam int IDX_W    = 10;
    localparam int INT_W    = 8;
    localparam int PROD_W   = 64;
    localparam int DIVD_W   = ITER_W + INT_W;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register map, index = paddr / 4
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_ORIGIN_REAL = 3'd0;
    localparam logic [2:0] REG_ORIGIN_IMAG = 3'd1;
    localparam logic [2:0] REG_STEP_REAL   = 3'd2;
    localparam logic [2:0] REG_STEP_IMAG   = 3'd3;
    localparam logic [2:0] REG_MAX_ITER    = 3'd4;

    // register reset values
    localparam logic signed [WORD_W-1:0] ORIGIN_REAL_RST = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] ORIGIN_IMAG_RST = -32'sd536870912;
    localparam logic [STEP_W-1:0]        STEP_REAL_RST   = 31'd1048576;
    localparam logic [STEP_W-1:0]        STEP_IMAG_RST   = 31'd1048576;
    localparam logic [ITER_W-1:0]        MAX_ITER_RST    = 16'd100;

    // saturation limits and escape radius squared
    localparam logic signed [PROD_W-1:0] WORD_MAX_W = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] WORD_MIN_W = -64'sd2147483648;
    localparam logic signed [PROD_W-1:0] FOUR_W     = 64'sd4 <<< FRAC_BITS;

    // complex point handed from front to back
    typedef struct packed {
        logic signed [WORD_W-1:0] cr;
        logic signed [WORD_W-1:0] ci;
    } point_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [ITER_W-1:0] divisor;
    } div_req_t;

    // clamp a wide signed value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WORD_MAX_W) begin
            r = WORD_MAX_W[WORD_W-1:0];
        end else if (v < WORD_MIN_W) begin
            r = WORD_MIN_W[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/mandelbrot_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// Escape-time evaluator: pixel index in, intensity, count and escape flag out.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata: column[9:0], row[19:10]
//  m_*       out        tdata: intensity[7:0], escape_count[23:8]; tuser: escaped
//  apb       in/out     origin_real 0x00, origin_imag 0x04, step_real 0x08,
//                       step_imag 0x0c, max_iter 0x10
//
// Each pixel runs its iteration steps on the shared complex-step unit
// (multiply state, then saturate/test/update state), then the divider
// when it escapes, with entry and exit states around them.
// The front maps up to 4 points ahead into its queue while the engine works.
// Reset is synchronous, active low; registers return to their defaults.
// A stalled result holds in the output register; the engine waits to deliver.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // pixel input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // column[9:0], row[19:10]
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // intensity[7:0], escape_count[23:8]
    output logic                        m_tuser,   // escaped
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [met_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import met_pkg::*;

    logic signed [WORD_W-1:0] origin_real_reg, origin_imag_reg;
    logic [STEP_W-1:0]        step_real_reg, step_imag_reg;
    logic [ITER_W-1:0]        max_iter_reg;
    logic                     wr_en;
    logic [2:0]               reg_idx;
    logic                     push, pop, empty;
    point_t                   push_data, head;
    logic [QCNT_W-1:0]        level;

    // register writes
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_real_reg <= ORIGIN_REAL_RST;
            origin_imag_reg <= ORIGIN_IMAG_RST;
            step_real_reg   <= STEP_REAL_RST;
            step_imag_reg   <= STEP_IMAG_RST;
            max_iter_reg    <= MAX_ITER_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ORIGIN_REAL: origin_real_reg <= pwdata;
                REG_ORIGIN_IMAG: origin_imag_reg <= pwdata;
                REG_STEP_REAL:   step_real_reg   <= pwdata[STEP_W-1:0];
                REG_STEP_IMAG:   step_imag_reg   <= pwdata[STEP_W-1:0];
                REG_MAX_ITER:    max_iter_reg    <= pwdata[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_REAL: prdata = origin_real_reg;
            REG_ORIGIN_IMAG: prdata = origin_imag_reg;
            REG_STEP_REAL:   prdata = {1'b0, step_real_reg};
            REG_STEP_IMAG:   prdata = {1'b0, step_imag_reg};
            REG_MAX_ITER:    prdata = {16'b0, max_iter_reg};
            default:         prdata = '0;
        endcase
    end

    // index to point mapping
    met_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .origin_real (origin_real_reg),
        .origin_imag (origin_imag_reg),
        .step_real   (step_real_reg),
        .step_imag   (step_imag_reg),
        .q_level     (level),
        .push        (push),
        .push_data   (push_data)
    );

    // point queue
    met_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .level     (level)
    );

    // iteration engine and output register
    met_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_head   (head),
        .q_pop    (pop),
        .max_iter (max_iter_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> design/met_fifo.sv
// ----------------------------------------------------------------------------
// met_fifo
// Small queue of complex points between the front and the iteration engine.
// ----------------------------------------------------------------------------
module met_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  met_pkg::point_t         push_data,
    input  logic                    pop,
    output met_pkg::point_t         head,
    output logic                    empty,
    output logic [met_pkg::QCNT_W-1:0] level
);
    import met_pkg::*;

    point_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

endmodule

>>> design/met_front.sv
// ----------------------------------------------------------------------------
// met_front
// Takes pixel indexes, clamps them to the image and maps them to a point c.
// ----------------------------------------------------------------------------
module met_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // column[9:0], row[19:10]
    input  logic signed [met_pkg::WORD_W-1:0] origin_real,
    input  logic signed [met_pkg::WORD_W-1:0] origin_imag,
    input  logic [met_pkg::STEP_W-1:0]        step_real,
    input  logic [met_pkg::STEP_W-1:0]        step_imag,
    input  logic [met_pkg::QCNT_W-1:0]        q_level,
    output logic                              push,
    output met_pkg::point_t                   push_data
);
    import met_pkg::*;

    localparam int OFS_W = IDX_W + STEP_W;

    logic [IDX_W-1:0] column, row;
    logic [IDX_W-1:0] col_c, row_c;
    logic             accept;
    logic             v1_reg, v1_next;
    logic [OFS_W-1:0] ofs_re_reg, ofs_re_next;
    logic [OFS_W-1:0] ofs_im_reg, ofs_im_next;

    assign column = s_tdata[IDX_W-1:0];
    assign row    = s_tdata[2*IDX_W-1:IDX_W];

    // clamp indexes beyond the image to the last column or row
    assign col_c = ({3'b0, column} >= 13'(IMAGE_WIDTH))  ? IDX_W'(IMAGE_WIDTH - 1)  : column;
    assign row_c = ({3'b0, row}    >= 13'(IMAGE_HEIGHT)) ? IDX_W'(IMAGE_HEIGHT - 1) : row;

    // room for the item in flight and the new one
    assign s_tready = ({1'b0, q_level} + (QCNT_W + 1)'(v1_reg)) < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // stage one: index times step
    always_comb begin
        v1_next     = accept;
        ofs_re_next = OFS_W'(col_c) * OFS_W'(step_real);
        ofs_im_next = OFS_W'(row_c) * OFS_W'(step_imag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        ofs_re_reg <= ofs_re_next;
        ofs_im_reg <= ofs_im_next;
    end

    // stage two: add origin, saturate, push into the queue
    assign push         = v1_reg;
    assign push_data.cr = sat_word($signed(PROD_W'(ofs_re_reg)) + PROD_W'(origin_real));
    assign push_data.ci = sat_word($signed(PROD_W'(ofs_im_reg)) + PROD_W'(origin_imag));

endmodule

>>> design/met_div.sv
// ----------------------------------------------------------------------------
// met_div
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// ----------------------------------------------------------------------------
module met_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  met_pkg::div_req_t             req,
    output logic                          done,
    output logic [met_pkg::INT_W-1:0]     quotient
);
    import met_pkg::*;

    localparam int CNT_W = $clog2(INT_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ITER_W-1:0] rem_reg, rem_next;
    logic [INT_W-1:0]  bits_reg, bits_next;
    logic [INT_W-1:0]  q_reg, q_next;
    logic [ITER_W-1:0] dsr_reg, dsr_next;
    logic              done_reg, done_next;
    logic [ITER_W:0]   shifted;
    logic [ITER_W:0]   trial;

    // quotient below 256 keeps the upper dividend bits below the divisor
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, bits_reg[INT_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(INT_W - 1);
            rem_next  = req.dividend[DIVD_W-1:INT_W];
            bits_next = req.dividend[INT_W-1:0];
            dsr_next  = req.divisor;
            q_next    = '0;
        end else if (busy_reg) begin
            if (!trial[ITER_W]) begin
                rem_next = trial[ITER_W-1:0];
            end else begin
                rem_next = shifted[ITER_W-1:0];
            end
            q_next    = {q_reg[INT_W-2:0], ~trial[ITER_W]};
            bits_next = {bits_reg[INT_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> design/met_core.sv
// ----------------------------------------------------------------------------
// met_core
// Iteration engine: z = z*z + c on one shared complex-step unit, then scaling.
// ----------------------------------------------------------------------------
module met_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  met_pkg::point_t               q_head,
    output logic                          q_pop,
    input  logic [met_pkg::ITER_W-1:0]    max_iter,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // intensity[7:0], escape_count[23:8]
    output logic                          m_tuser    // escaped
);
    import met_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_STEP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [WORD_W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [WORD_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [PROD_W-1:0] prr_reg, prr_next, pii_reg, pii_next, pri_reg, pri_next;
    logic [ITER_W-1:0]        k_reg, k_next;
    logic [ITER_W-1:0]        cnt_reg, cnt_next;
    logic                     esc_reg, esc_next;
    logic [INT_W-1:0]         inten_reg, inten_next;
    logic                     ovalid_reg, ovalid_next;
    logic [INT_W-1:0]         o_inten_reg, o_inten_next;
    logic [ITER_W-1:0]        o_cnt_reg, o_cnt_next;
    logic                     o_esc_reg, o_esc_next;
    logic signed [WORD_W-1:0] r2, i2, ri, nr, ni;
    logic                     escape;
    logic [ITER_W:0]          k_inc;
    logic                     out_free;
    div_req_t                 div_req;
    logic                     div_done;
    logic [INT_W-1:0]         div_q;

    // shared complex-step unit, second half: shift, saturate, test, update
    always_comb begin
        r2     = sat_word(prr_reg >>> FRAC_BITS);
        i2     = sat_word(pii_reg >>> FRAC_BITS);
        ri     = sat_word(pri_reg >>> (FRAC_BITS - 1));
        escape = (PROD_W'(r2) + PROD_W'(i2)) > FOUR_W;
        ni     = sat_word(PROD_W'(ri) + PROD_W'(ci_reg));
        nr     = sat_word(PROD_W'(r2) - PROD_W'(i2) + PROD_W'(cr_reg));
        k_inc  = {1'b0, k_reg} + 1'b1;
    end

    assign out_free = !ovalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        prr_next     = prr_reg;
        pii_next     = pii_reg;
        pri_next     = pri_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        esc_next     = esc_reg;
        inten_next   = inten_reg;
        q_pop        = 1'b0;
        div_req      = '0;
        ovalid_next  = ovalid_reg && !m_tready;
        o_inten_next = o_inten_reg;
        o_cnt_next   = o_cnt_reg;
        o_esc_next   = o_esc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cr_next    = q_head.cr;
                    ci_next    = q_head.ci;
                    zr_next    = q_head.cr;
                    zi_next    = q_head.ci;
                    k_next     = '0;
                    cnt_next   = '0;
                    esc_next   = 1'b0;
                    inten_next = '0;
                    state_next = (max_iter == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                prr_next   = PROD_W'(zr_reg) * PROD_W'(zr_reg);
                pii_next   = PROD_W'(zi_reg) * PROD_W'(zi_reg);
                pri_next   = PROD_W'(zr_reg) * PROD_W'(zi_reg);
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (escape) begin
                    esc_next   = 1'b1;
                    cnt_next   = k_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = ({INT_W'(0), k_reg} << INT_W) - {INT_W'(0), k_reg};
                    div_req.divisor  = max_iter;
                    state_next = ST_DIV;
                end else begin
                    zr_next = nr;
                    zi_next = ni;
                    k_next  = k_inc[ITER_W-1:0];
                    state_next = (k_inc == {1'b0, max_iter}) ? ST_DONE : ST_MUL;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    inten_next = div_q;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ovalid_next  = 1'b1;
                    o_inten_next = inten_reg;
                    o_cnt_next   = cnt_reg;
                    o_esc_next   = esc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        zr_reg      <= zr_next;
        zi_reg      <= zi_next;
        prr_reg     <= prr_next;
        pii_reg     <= pii_next;
        pri_reg     <= pri_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        esc_reg     <= esc_next;
        inten_reg   <= inten_next;
        o_inten_reg <= o_inten_next;
        o_cnt_reg   <= o_cnt_next;
        o_esc_reg   <= o_esc_next;
    end

    // intensity scaling: count*255 / max_iter
    met_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {o_cnt_reg, o_inten_reg};
    assign m_tuser  = o_esc_reg;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-time pixel unit. Pixel items are queued
// by a stimulus process and driven by a clocked driver. Two monitors watch the
// channels. Each accepted pixel is run through a local fixed-point escape-time
// predictor, and each result item is checked field by field against the
// oldest prediction. The view registers are set over APB between phases and
// read back. Both channels idle and stall at random, with one phase that
// runs with no idling at all.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] column;
    } pixel_t;

    typedef struct packed {
        logic [INT_W-1:0]  intensity;
        logic [ITER_W-1:0] count;
        logic              escaped;
    } pixel_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata  = '0;   // column[9:0], row[19:10]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;         // intensity[7:0], escape_count[23:8]
    logic              m_tuser;         // escaped
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // local copy of the view registers
    logic signed [WORD_W-1:0] origin_re = ORIGIN_REAL_RST;
    logic signed [WORD_W-1:0] origin_im = ORIGIN_IMAG_RST;
    logic [STEP_W-1:0]        step_re   = STEP_REAL_RST;
    logic [STEP_W-1:0]        step_im   = STEP_IMAG_RST;
    logic [ITER_W-1:0]        iter_limit = MAX_ITER_RST;

    pixel_t        pixel_pending_q[$];
    pixel_result_t result_expected_q[$];
    int            failures = 0;
    bit            steady   = 1'b0;

    mandelbrot_escape_time_pixel_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        failures++;
    endtask

    // clamp to the signed word range
    function automatic longint clamp_word(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // escape-time prediction for one pixel under the current view
    function automatic pixel_result_t escape_time(input logic [IDX_W-1:0] col_in,
                                                  input logic [IDX_W-1:0] row_in);
        longint        cr, ci, zr, zi, sq_re, sq_im, next_re, next_im, radius_sq;
        int            col, row;
        int unsigned   k, limit;
        pixel_result_t r;
        r = '0;
        col = int'(col_in);
        row = int'(row_in);
        if (col >= IMAGE_WIDTH) begin
            col = IMAGE_WIDTH - 1;
        end
        if (row >= IMAGE_HEIGHT) begin
            row = IMAGE_HEIGHT - 1;
        end
        radius_sq = longint'(4) <<< FRAC_BITS;
        limit = 32'(iter_limit);
        cr = clamp_word(longint'(origin_re) + longint'(col) * longint'(step_re));
        ci = clamp_word(longint'(origin_im) + longint'(row) * longint'(step_im));
        zr = cr;
        zi = ci;
        for (k = 0; k < limit; k++) begin
            sq_re = clamp_word((zr * zr) >>> FRAC_BITS);
            sq_im = clamp_word((zi * zi) >>> FRAC_BITS);
            if (sq_re + sq_im > radius_sq) begin
                r.escaped = 1'b1;
                r.count = k[ITER_W-1:0];
                break;
            end
            // doubled cross term comes from one bit less of shift
            next_im = clamp_word(clamp_word((zr * zi) >>> (FRAC_BITS - 1)) + ci);
            next_re = clamp_word(sq_re - sq_im + cr);
            zr = next_re;
            zi = next_im;
        end
        if (r.escaped && limit != 0) begin
            r.intensity = INT_W'((int'(r.count) * 255) / limit);
        end
        return r;
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_pending_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
                s_tdata  <= {4'd0, pixel_pending_q[0].row, pixel_pending_q[0].column};
                s_tvalid <= 1'b1;
                void'(pixel_pending_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // input monitor: predict each accepted pixel
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            result_expected_q.push_back(escape_time(s_tdata[9:0], s_tdata[19:10]));
        end
    end

    // result monitor and backpressure
    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result item with none expected, tdata %h",
                                              m_tdata));
                end else begin
                    want = result_expected_q.pop_front();
                    if (m_tdata[7:0] !== want.intensity) begin
                        report_mismatch($sformatf("intensity %0d, expected %0d",
                                                  m_tdata[7:0], want.intensity));
                    end
                    if (m_tdata[23:8] !== want.count) begin
                        report_mismatch($sformatf("escape_count %0d, expected %0d",
                                                  m_tdata[23:8], want.count));
                    end
                    if (m_tuser !== want.escaped) begin
                        report_mismatch($sformatf("escaped %b, expected %b",
                                                  m_tuser, want.escaped));
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 15);
        end
    end

    // one register write, then read it back
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        if (index == REG_MAX_ITER) begin
            mask = 32'h0000_ffff;
        end else if (index == REG_STEP_REAL || index == REG_STEP_IMAG) begin
            mask = 32'h7fff_ffff;
        end else begin
            mask = 32'hffff_ffff;
        end
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        unique case (index)
            REG_ORIGIN_REAL: origin_re = value;
            REG_ORIGIN_IMAG: origin_im = value;
            REG_STEP_REAL:   step_re = value[STEP_W-1:0];
            REG_STEP_IMAG:   step_im = value[STEP_W-1:0];
            REG_MAX_ITER:    iter_limit = value[ITER_W-1:0];
            default: ;
        endcase
        // read transfer at the same address
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((readback & mask) !== (value & mask)) begin
            report_mismatch($sformatf("register %0d reads %h, written %h",
                                      index, readback & mask, value & mask));
        end
    endtask

    task automatic load_view(input logic [31:0] o_re, input logic [31:0] o_im,
                             input logic [31:0] s_re, input logic [31:0] s_im,
                             input logic [31:0] limit);
        write_register(REG_ORIGIN_REAL, o_re);
        write_register(REG_ORIGIN_IMAG, o_im);
        write_register(REG_STEP_REAL, s_re);
        write_register(REG_STEP_IMAG, s_im);
        write_register(REG_MAX_ITER, limit);
    endtask

    task automatic queue_pixel(input int col, input int row);
        pixel_t p;
        p.column = col[IDX_W-1:0];
        p.row    = row[IDX_W-1:0];
        pixel_pending_q.push_back(p);
    endtask

    // sender holds off until every expected result item is back
    task automatic wait_all_results();
        do @(negedge aclk);
        while (pixel_pending_q.size() != 0 || s_tvalid || result_expected_q.size() != 0);
    endtask

    // stimulus
    initial begin
        logic [31:0] o_re, o_im, s_re, s_im, limit;
        int          phase, n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // default view, -2..2 on both axes at 1/256 per pixel
        queue_pixel(0, 0);          // far corner, escapes at step zero
        queue_pixel(1023, 1023);
        queue_pixel(1023, 0);
        queue_pixel(0, 1023);
        queue_pixel(512, 512);      // origin, never escapes
        queue_pixel(256, 512);      // c = -1, bounded cycle
        queue_pixel(0, 512);        // c = -2, magnitude sits exactly on the radius
        queue_pixel(576, 512);      // c = 0.25, cusp
        queue_pixel(599, 512);      // just outside the cusp, slow escape
        queue_pixel(420, 680);
        queue_pixel(600, 700);
        queue_pixel(341, 853);
        wait_all_results();

        // single step
        load_view(ORIGIN_REAL_RST, ORIGIN_IMAG_RST, 32'(STEP_REAL_RST), 32'(STEP_IMAG_RST),
                  32'd1);
        queue_pixel(0, 0);
        queue_pixel(512, 512);
        queue_pixel(700, 300);
        wait_all_results();

        // no step tried at all
        load_view(ORIGIN_REAL_RST, ORIGIN_IMAG_RST, 32'(STEP_REAL_RST), 32'(STEP_IMAG_RST),
                  32'd0);
        queue_pixel(0, 0);
        queue_pixel(512, 512);
        wait_all_results();

        // extreme origins and steps, coordinates saturate
        load_view(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(1023, 0);
        queue_pixel(0, 1023);
        wait_all_results();

        // every pixel maps to zero, runs the full iteration budget
        load_view(32'h0, 32'h0, 32'h0, 32'h0, 32'hffff);
        queue_pixel(1023, 1023);
        wait_all_results();

        // random views over the set, one phase without idling
        for (phase = 0; phase < 8; phase++) begin
            o_re  = -671088640 + $urandom_range(939524096);
            o_im  = -402653184 + $urandom_range(268435456);
            s_re  = $urandom_range(1 << 21, 1 << 17);
            s_im  = $urandom_range(1 << 21, 1 << 17);
            limit = $urandom_range(120, 1);
            if ($urandom_range(3) == 0) begin
                o_re = $urandom;
            end
            if ($urandom_range(3) == 0) begin
                o_im = $urandom;
            end
            if ($urandom_range(4) == 0) begin
                s_re = $urandom & 32'h7fff_ffff;
            end
            if ($urandom_range(4) == 0) begin
                s_im = $urandom & 32'h7fff_ffff;
            end
            if ($urandom_range(3) == 0) begin
                limit = $urandom_range(300, 121);
            end
            load_view(o_re, o_im, s_re, s_im, limit);
            steady = (phase == 2);
            for (n = 0; n < 85; n++) begin
                queue_pixel($urandom_range(1023), $urandom_range(1023));
            end
            wait_all_results();
        end
        steady = 1'b0;

        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
